/* src/png_post_idat_chunk_extractor_core_defines.svh */
// ----------------------------------------------------------------------------
// png chunk extractor assertion macros
// shared concurrent assertion forms, clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef PNG_POST_IDAT_CHUNK_EXTRACTOR_CORE_DEFINES_SVH
`define PNG_POST_IDAT_CHUNK_EXTRACTOR_CORE_DEFINES_SVH

// same-cycle implication
`define PNGX_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pngx assertion failed");

// next-cycle implication
`define PNGX_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pngx assertion failed");

`endif

/* src/pngx_pkg.sv */
// ----------------------------------------------------------------------------
// pngx_pkg
// types and constants shared by the png chunk extractor modules
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pngx_pkg;

	// default length of the leading signature
	localparam int SIG_BYTES_DEF = 8;

	// header layout: 4 length bytes then 4 type bytes
	localparam int FIELD_BYTES = 4;
	localparam int HDR_BYTES   = 8;

	// chunk type letters
	localparam logic [7:0] CH_I = 8'h49;
	localparam logic [7:0] CH_D = 8'h44;
	localparam logic [7:0] CH_A = 8'h41;
	localparam logic [7:0] CH_T = 8'h54;
	localparam logic [7:0] CH_E = 8'h45;
	localparam logic [7:0] CH_N = 8'h4E;

	// parser phase
	typedef enum logic [2:0] {
		PH_SIG,
		PH_LEN,
		PH_TYPE,
		PH_DATA,
		PH_CRC,
		PH_DONE
	} phase_t;

	// copy progress
	typedef enum logic [1:0] {
		CM_SEEK,
		CM_IDAT,
		CM_COPY
	} copy_mode_t;

	// what one input item produces
	typedef enum logic [1:0] {
		RES_NONE,
		RES_ONE,
		RES_RUN
	} res_kind_t;

	typedef struct packed {
		res_kind_t                  kind;
		logic [HDR_BYTES-1:0][7:0] bytes;  // bytes[0] goes out first
	} result_t;

endpackage

/* src/pngx_parser.sv */
// ----------------------------------------------------------------------------
// pngx_parser
// chunk parser state and per-item result decode
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "png_post_idat_chunk_extractor_core_defines.svh"

module pngx_parser
	import pngx_pkg::*;
#(
	parameter int SIGNATURE_BYTES = SIG_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] in_byte,
	output result_t    res
);

	localparam logic [31:0] SIG_INIT = 32'(SIGNATURE_BYTES % 16);
	localparam logic [2:0]  LEN_LAST  = 3'(FIELD_BYTES - 1);
	localparam logic [2:0]  TYPE_LAST = 3'(HDR_BYTES - 1);

	phase_t     phase_q, phase_d;
	copy_mode_t copy_q, copy_d;
	logic [2:0]  count_q, count_d;
	logic [31:0] len_q, len_d;
	logic [31:0] remain_q, remain_d;
	logic [7:0]  hdr_q [HDR_BYTES];
	logic        is_idat;
	logic        is_iend;

	// type tests: the data-chunk test takes its last type byte as it arrives; the end-chunk test reads stored bytes
	assign is_idat = (hdr_q[4] == CH_I) && (hdr_q[5] == CH_D) &&
		(hdr_q[6] == CH_A) && (in_byte == CH_T);
	assign is_iend = (hdr_q[4] == CH_I) && (hdr_q[5] == CH_E) &&
		(hdr_q[6] == CH_N) && (hdr_q[7] == CH_D);

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= (SIG_INIT != 32'd0) ? PH_SIG : PH_LEN;
			copy_q   <= CM_SEEK;
			count_q  <= 3'd0;
			len_q    <= 32'd0;
			remain_q <= SIG_INIT;
		end else if (accept) begin
			phase_q  <= phase_d;
			copy_q   <= copy_d;
			count_q  <= count_d;
			len_q    <= len_d;
			remain_q <= remain_d;
		end
	end

	// header byte store, indexed by position in length and type fields
	always_ff @(posedge clk) begin
		if (accept && (phase_q == PH_LEN || phase_q == PH_TYPE)) begin
			hdr_q[count_q] <= in_byte;
		end
	end

	// next state and result decode
	always_comb begin
		phase_d  = phase_q;
		copy_d   = copy_q;
		count_d  = count_q;
		len_d    = len_q;
		remain_d = remain_q;
		res.kind = RES_NONE;
		for (int k = 0; k < HDR_BYTES - 1; k++) begin
			res.bytes[k] = hdr_q[k];
		end
		res.bytes[HDR_BYTES-1] = in_byte;

		unique case (phase_q)
			PH_SIG: begin
				remain_d = remain_q - 32'd1;
				if (remain_q == 32'd1) begin
					phase_d = PH_LEN;
					count_d = 3'd0;
				end
			end
			PH_LEN: begin
				len_d   = {len_q[23:0], in_byte};
				count_d = count_q + 3'd1;
				if (count_q == LEN_LAST) begin
					phase_d = PH_TYPE;
				end
			end
			PH_TYPE: begin
				count_d = count_q + 3'd1;
				if (count_q == TYPE_LAST) begin
					if (is_idat) begin
						if (copy_q == CM_SEEK) begin
							copy_d = CM_IDAT;
						end
					end else if (copy_q == CM_IDAT) begin
						copy_d = CM_COPY;
					end
					if (copy_d == CM_COPY) begin
						res.kind = RES_RUN;
					end
					remain_d = len_q;
					phase_d  = (len_q != 32'd0) ? PH_DATA : PH_CRC;
				end
			end
			PH_DATA: begin
				if (copy_q == CM_COPY) begin
					res.kind     = RES_ONE;
					res.bytes[0] = in_byte;
				end
				remain_d = remain_q - 32'd1;
				if (remain_q == 32'd1) begin
					phase_d = PH_CRC;
					count_d = 3'd0;
				end
			end
			PH_CRC: begin
				if (copy_q == CM_COPY) begin
					res.kind     = RES_ONE;
					res.bytes[0] = in_byte;
				end
				count_d = count_q + 3'd1;
				if (count_q == LEN_LAST) begin
					count_d = 3'd0;
					len_d   = 32'd0;
					phase_d = is_iend ? PH_DONE : PH_LEN;
				end
			end
			default: begin
			end
		endcase
	end

	// after the end chunk nothing moves again
	`PNGX_ASSERT_NEXT(a_done_sticks, phase_q == PH_DONE, phase_q == PH_DONE)
	// length and crc fields never count past four bytes
	`PNGX_ASSERT_NOW(a_field_count, phase_q == PH_LEN || phase_q == PH_CRC, count_q <= LEN_LAST)

endmodule

/* src/pngx_out_buf.sv */
// ----------------------------------------------------------------------------
// pngx_out_buf
// result register: holds one result or one 8-byte header run and drains it
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "png_post_idat_chunk_extractor_core_defines.svh"

module pngx_out_buf
	import pngx_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       load,
	input  result_t    res,
	output logic       can_load,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_byte
	output logic       m_tlast
);

	logic [3:0] count_q;
	logic [7:0] data_q [HDR_BYTES];
	logic       pop;

	assign pop      = m_tvalid && m_tready;
	assign can_load = (count_q == 4'd0) || (count_q == 4'd1 && pop);
	assign m_tvalid = (count_q != 4'd0);
	assign m_tdata  = data_q[0];
	assign m_tlast  = (count_q == 4'd1);

	// fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 4'd0;
		end else if (load && res.kind == RES_RUN) begin
			count_q <= 4'(HDR_BYTES);
		end else if (load && res.kind == RES_ONE) begin
			count_q <= 4'd1;
		end else if (pop) begin
			count_q <= count_q - 4'd1;
		end
	end

	// byte storage: load a run or a single byte, shift down on each take
	always_ff @(posedge clk) begin
		if (load && res.kind == RES_RUN) begin
			for (int k = 0; k < HDR_BYTES; k++) begin
				data_q[k] <= res.bytes[k];
			end
		end else if (load && res.kind == RES_ONE) begin
			data_q[0] <= res.bytes[0];
		end else if (pop) begin
			for (int k = 0; k < HDR_BYTES - 1; k++) begin
				data_q[k] <= data_q[k+1];
			end
		end
	end

	// never more than one header run held
	`PNGX_ASSERT_NOW(a_count_max, 1'b1, count_q <= 4'(HDR_BYTES))
	// a header run always comes out as eight items
	`PNGX_ASSERT_NEXT(a_run_fill, load && res.kind == RES_RUN, count_q == 4'(HDR_BYTES))

endmodule

/* src/png_post_idat_chunk_extractor_core.sv */
// a result is offered on m_tdata in the cycle after its input item is taken
// throughput: one input item per cycle while m_tready is high and no header run is draining
// a copied chunk header leaves as a run of 8 items, holding off input until its last item is taken
// the 8-entry output register and its fill count set the stall while a run drains
// reset (arst_n low) returns to signature skip (length phase if SIGNATURE_BYTES % 16 is 0), copying off, output empty
// ----------------------------------------------------------------------------
// png_post_idat_chunk_extractor_core
// passes through every png chunk that follows the image data chunks
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module png_post_idat_chunk_extractor_core
	import pngx_pkg::*;
#(
	parameter int SIGNATURE_BYTES = SIG_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] in_byte
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_byte
	output logic       m_tlast    // run_last
);

	logic    accept;
	logic    can_load;
	result_t res;

	assign s_tready = can_load;
	assign accept   = s_tvalid && s_tready;

	// chunk parser
	pngx_parser #(
		.SIGNATURE_BYTES(SIGNATURE_BYTES)
	) u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.in_byte(s_tdata),
		.res    (res)
	);

	// output register
	pngx_out_buf u_out_buf (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (accept),
		.res     (res),
		.can_load(can_load),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

endmodule
